// ===== rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle property check, switched off while reset is asserted.
`define SAH_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that holds in the cycle after the antecedent.
`define SAH_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/sah_pkg.sv =====
`default_nettype none

package sah_pkg;

  localparam int unsigned MaxCapacityDef   = 65536;
  localparam int unsigned MinAlign         = 8;
  localparam int unsigned HeaderBytes      = 16;
  localparam int unsigned HeaderAlignLog2  = 3;
  localparam int unsigned HeaderAlign      = 1 << HeaderAlignLog2;
  localparam int unsigned BaseAlign        = (MinAlign > HeaderAlign) ? MinAlign : HeaderAlign;

  localparam int unsigned OffW    = 17;
  localparam int unsigned AlignW  = 13;
  localparam int unsigned CountW  = 13;
  localparam int unsigned TotalW  = 32;
  localparam int unsigned HdrIdxW = OffW - HeaderAlignLog2;

  // Largest value the capacity register can hold.
  localparam int unsigned CapRegMax = (1 << OffW) - 1;
  localparam logic [OffW-1:0] CapReset = OffW'(65536);

  typedef enum logic [1:0] {
    REQ_ALLOC = 2'd0,
    REQ_FREE  = 2'd1,
    REQ_CLEAR = 2'd2
  } req_type_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_ZERO_SIZE = 3'd1,
    ST_EXHAUSTED = 3'd2,
    ST_BAD_ALIGN = 3'd3,
    ST_FOREIGN   = 3'd4,
    ST_NOT_TOP   = 3'd5
  } status_e;

  typedef enum logic {
    CS_IDLE,
    CS_EXEC
  } ctrl_state_e;

  typedef struct packed {
    logic [OffW-1:0] prev_top;
    logic [OffW-1:0] blk_end;
  } hdr_t;

  typedef struct packed {
    logic               rd_en;
    logic               wr_en;
    logic [HdrIdxW-1:0] rd_idx;
    logic [HdrIdxW-1:0] wr_idx;
    hdr_t               wr_data;
  } hdr_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/sah_if.sv =====
`default_nettype none

interface sah_req_if import sah_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        req_type;
  logic [OffW-1:0]   size_bytes;
  logic [AlignW-1:0] align_bytes;
  logic [OffW-1:0]   release_offset;
  logic              release_is_null;

  modport source (
    output valid, req_type, size_bytes, align_bytes, release_offset, release_is_null,
    input  ready
  );
  modport sink (
    input  valid, req_type, size_bytes, align_bytes, release_offset, release_is_null,
    output ready
  );
endinterface

interface sah_rsp_if import sah_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [2:0]        status;
  logic [OffW-1:0]   grant_offset;
  logic [OffW-1:0]   top_offset;
  logic [CountW-1:0] live_count;
  logic [OffW-1:0]   peak_usage;
  logic [TotalW-1:0] total_allocs;
  logic [TotalW-1:0] total_frees;
  logic [OffW-1:0]   waste_bytes;

  modport source (
    output valid, status, grant_offset, top_offset, live_count, peak_usage,
           total_allocs, total_frees, waste_bytes,
    input  ready
  );
  modport sink (
    input  valid, status, grant_offset, top_offset, live_count, peak_usage,
           total_allocs, total_frees, waste_bytes,
    output ready
  );
endinterface

`default_nettype wire

// ===== rtl/sah_hdr_mem.sv =====
`default_nettype none

module sah_hdr_mem import sah_pkg::*; #(
  parameter int unsigned Depth = MaxCapacityDef / HeaderAlign
) (
  input  wire logic     clk_i,
  input  wire hdr_cmd_t cmd_i,
  output hdr_t          rd_data_o
);

  localparam int unsigned IdxW = $clog2(Depth);

  hdr_t mem_q [Depth];
  hdr_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem_q[cmd_i.wr_idx[IdxW-1:0]] <= cmd_i.wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      rd_data_q <= mem_q[cmd_i.rd_idx[IdxW-1:0]];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

// ===== rtl/sah_core.sv =====
`default_nettype none

module sah_core import sah_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic [OffW-1:0] cap_i,
  sah_req_if.sink              req_i,
  sah_rsp_if.source            rsp_o,
  output hdr_cmd_t             hdr_cmd_o,
  input  wire hdr_t            hdr_rdata_i
);

  localparam logic [AlignW-1:0] BaseAlignW = AlignW'(BaseAlign);
  localparam logic [OffW:0]     HdrBytes18 = (OffW+1)'(HeaderBytes);
  localparam logic [OffW-1:0]   HdrBytes17 = OffW'(HeaderBytes);
  localparam logic [OffW-1:0]   AlignMask  = OffW'(HeaderAlign - 1);

  ctrl_state_e state_q, state_d;

  // Request captured at accept, with the checks that need no header.
  logic [1:0]      type_q;
  logic [OffW-1:0] size_q;
  logic [OffW-1:0] off_q;
  logic [OffW:0]   user_q;
  status_e         pre_st_q;

  logic [OffW-1:0]   top_q, top_d;
  logic [OffW-1:0]   peak_q, peak_d;
  logic [CountW-1:0] live_q, live_d;
  logic [TotalW-1:0] allocs_q, allocs_d;
  logic [TotalW-1:0] frees_q, frees_d;
  logic [OffW-1:0]   waste_q, waste_d;

  logic              rsp_valid_q;
  status_e           out_status_q, st_d;
  logic [OffW-1:0]   out_user_q, granted_d;
  logic [OffW-1:0]   out_top_q;
  logic [CountW-1:0] out_live_q;
  logic [OffW-1:0]   out_peak_q;
  logic [TotalW-1:0] out_allocs_q;
  logic [TotalW-1:0] out_frees_q;
  logic [OffW-1:0]   out_waste_q;

  logic accept, slot_free, fire;

  assign req_i.ready = (state_q == CS_IDLE);
  assign accept      = req_i.valid && req_i.ready;
  assign slot_free   = !rsp_valid_q || rsp_o.ready;
  assign fire        = (state_q == CS_EXEC) && slot_free;

  // Accept-cycle work: alignment, user offset, offset validity.
  logic [AlignW-1:0] align_m1, eff_align, eff_m1;
  logic              align_bad, foreign;
  logic [OffW:0]     user_d;
  status_e           pre_st_d;

  always_comb begin
    align_m1  = req_i.align_bytes - AlignW'(1);
    align_bad = (req_i.align_bytes == '0) || ((req_i.align_bytes & align_m1) != '0);
    eff_align = (req_i.align_bytes > BaseAlignW) ? req_i.align_bytes : BaseAlignW;
    eff_m1    = eff_align - AlignW'(1);
    user_d    = ((OffW+1)'(top_q) + HdrBytes18 + (OffW+1)'(eff_m1))
                & ~((OffW+1)'(eff_m1));
    foreign   = (req_i.release_offset >= cap_i) ||
                (req_i.release_offset < HdrBytes17) ||
                ((req_i.release_offset & AlignMask) != '0);
    pre_st_d  = ST_OK;
    unique case (req_i.req_type)
      REQ_ALLOC: begin
        if (req_i.size_bytes == '0) begin
          pre_st_d = ST_ZERO_SIZE;
        end else if (align_bad) begin
          pre_st_d = ST_BAD_ALIGN;
        end
      end
      REQ_FREE: begin
        if (req_i.release_is_null) begin
          pre_st_d = ST_NOT_TOP;
        end else if (foreign) begin
          pre_st_d = ST_FOREIGN;
        end
      end
      default: pre_st_d = ST_OK;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      type_q   <= req_i.req_type;
      size_q   <= req_i.size_bytes;
      off_q    <= req_i.release_offset;
      user_q   <= user_d;
      pre_st_q <= pre_st_d;
    end
  end

  // Execute-cycle work: header is now out of the memory.
  logic [OffW+1:0] next_end;
  logic            exhausted;
  logic [OffW-1:0] alloc_waste;
  logic [OffW:0]   prev_plus;
  logic [OffW-1:0] free_waste, waste_sub;
  logic            hdr_wr;

  always_comb begin
    next_end    = (OffW+2)'(user_q) + (OffW+2)'(size_q);
    exhausted   = next_end > (OffW+2)'(cap_i);
    alloc_waste = OffW'(user_q - (OffW+1)'(top_q) - HdrBytes18);
    prev_plus   = (OffW+1)'(hdr_rdata_i.prev_top) + HdrBytes18;
    free_waste  = ((OffW+1)'(off_q) >= prev_plus) ?
                  OffW'((OffW+1)'(off_q) - prev_plus) : '0;
    waste_sub   = (free_waste < waste_q) ? free_waste : waste_q;

    st_d      = pre_st_q;
    granted_d = '0;
    hdr_wr    = 1'b0;
    top_d     = top_q;
    peak_d    = peak_q;
    live_d    = live_q;
    allocs_d  = allocs_q;
    frees_d   = frees_q;
    waste_d   = waste_q;

    unique case (type_q)
      REQ_ALLOC: begin
        if (pre_st_q == ST_OK) begin
          if (exhausted) begin
            st_d = ST_EXHAUSTED;
          end else begin
            hdr_wr    = 1'b1;
            granted_d = user_q[OffW-1:0];
            top_d     = next_end[OffW-1:0];
            if (next_end[OffW-1:0] > peak_q) begin
              peak_d = next_end[OffW-1:0];
            end
            live_d   = live_q + CountW'(1);
            allocs_d = allocs_q + TotalW'(1);
            waste_d  = waste_q + alloc_waste;
          end
        end
      end
      REQ_FREE: begin
        if (pre_st_q == ST_OK) begin
          if (hdr_rdata_i.blk_end != top_q) begin
            st_d = ST_NOT_TOP;
          end else begin
            top_d = hdr_rdata_i.prev_top;
            if (live_q != '0) begin
              live_d = live_q - CountW'(1);
            end
            frees_d = frees_q + TotalW'(1);
            waste_d = waste_q - waste_sub;
          end
        end
      end
      REQ_CLEAR: begin
        top_d    = '0;
        peak_d   = '0;
        live_d   = '0;
        allocs_d = '0;
        frees_d  = '0;
        waste_d  = '0;
      end
      default: st_d = ST_OK;
    endcase
  end

  // The header read is issued at accept; the write lands at the end of execute, so
  // the next read, which comes at a later accept, always sees it.
  always_comb begin
    hdr_cmd_o.rd_en            = accept && (req_i.req_type == REQ_FREE) && (pre_st_d == ST_OK);
    hdr_cmd_o.rd_idx           = req_i.release_offset[OffW-1:HeaderAlignLog2];
    hdr_cmd_o.wr_en            = fire && hdr_wr;
    hdr_cmd_o.wr_idx           = user_q[OffW-1:HeaderAlignLog2];
    hdr_cmd_o.wr_data.prev_top = top_q;
    hdr_cmd_o.wr_data.blk_end  = next_end[OffW-1:0];
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      CS_IDLE: begin
        if (accept) begin
          state_d = CS_EXEC;
        end
      end
      CS_EXEC: begin
        if (fire) begin
          state_d = CS_IDLE;
        end
      end
      default: state_d = CS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= CS_IDLE;
      rsp_valid_q <= 1'b0;
      top_q       <= '0;
      peak_q      <= '0;
      live_q      <= '0;
      allocs_q    <= '0;
      frees_q     <= '0;
      waste_q     <= '0;
    end else begin
      state_q <= state_d;
      if (fire) begin
        rsp_valid_q <= 1'b1;
        top_q       <= top_d;
        peak_q      <= peak_d;
        live_q      <= live_d;
        allocs_q    <= allocs_d;
        frees_q     <= frees_d;
        waste_q     <= waste_d;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_status_q <= st_d;
      out_user_q   <= granted_d;
      out_top_q    <= top_d;
      out_live_q   <= live_d;
      out_peak_q   <= peak_d;
      out_allocs_q <= allocs_d;
      out_frees_q  <= frees_d;
      out_waste_q  <= waste_d;
    end
  end

  assign rsp_o.valid        = rsp_valid_q;
  assign rsp_o.status       = out_status_q;
  assign rsp_o.grant_offset = out_user_q;
  assign rsp_o.top_offset   = out_top_q;
  assign rsp_o.live_count   = out_live_q;
  assign rsp_o.peak_usage   = out_peak_q;
  assign rsp_o.total_allocs = out_allocs_q;
  assign rsp_o.total_frees  = out_frees_q;
  assign rsp_o.waste_bytes  = out_waste_q;

endmodule

`default_nettype wire

// ===== rtl/stack_allocator_with_headers_unit.sv =====
// LIFO stack allocator over a byte buffer, with one header per block.
// req_i carries one request (allocate, deallocate, clear) per valid/ready
// handshake; rsp_o returns exactly one result per request, in order.
// cfg_we_i/cfg_wdata_i write the capacity register; values above the
// configured maximum capacity act as that maximum.
// Each request is handled in an accept cycle and an execute state: the accept
// cycle computes the aligned user offset and issues the header read, the
// execute state uses the registered header data, updates top and statistics,
// writes the new header and loads the output register. One request is in
// flight at a time: a new request is not taken until the last one has executed.
// rsp_o.valid is registered and rises when the execute state ends, which can
// happen only once the output register is free.
// When the receiver stalls, the result holds in the output register; one more
// request is accepted and waits in the execute state until the register frees.
// Reset clears top, peak and all counters and sets capacity to 65536. The
// header memory is not cleared; a deallocate should only name a header that an
// allocate wrote, which the block itself does not enforce.
`default_nettype none

module stack_allocator_with_headers_unit import sah_pkg::*; #(
  parameter int unsigned MaxCapacity = MaxCapacityDef
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  sah_req_if.sink              req_i,
  sah_rsp_if.source            rsp_o,
  input  wire logic            cfg_we_i,
  input  wire logic [OffW-1:0] cfg_wdata_i
);

  localparam int unsigned CapLimit = (MaxCapacity < CapRegMax) ? MaxCapacity : CapRegMax;
  localparam int unsigned HdrDepth = (CapLimit + HeaderAlign - 1) / HeaderAlign;
  localparam logic [OffW-1:0] CapLimitW = OffW'(CapLimit);

  logic [OffW-1:0] cap_q;
  logic [OffW-1:0] eff_cap;
  hdr_cmd_t        hdr_cmd;
  hdr_t            hdr_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CapReset;
    end else if (cfg_we_i) begin
      cap_q <= cfg_wdata_i;
    end
  end

  assign eff_cap = (cap_q > CapLimitW) ? CapLimitW : cap_q;

  sah_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cap_i       (eff_cap),
    .req_i       (req_i),
    .rsp_o       (rsp_o),
    .hdr_cmd_o   (hdr_cmd),
    .hdr_rdata_i (hdr_rdata)
  );

  sah_hdr_mem #(
    .Depth (HdrDepth)
  ) u_hdr_mem (
    .clk_i     (clk_i),
    .cmd_i     (hdr_cmd),
    .rd_data_o (hdr_rdata)
  );

endmodule

`default_nettype wire

// ===== rtl/sah_checker.sv =====
`default_nettype none

`include "assert_macros.svh"

module sah_checker import sah_pkg::*; (
  input wire logic            clk_i,
  input wire logic            rst_ni,
  input wire logic            req_valid_i,
  input wire logic            req_ready_i,
  input wire logic            rsp_valid_i,
  input wire logic            rsp_ready_i,
  input wire logic [2:0]      rsp_status_i,
  input wire logic [OffW-1:0] rsp_grant_i,
  input wire logic [OffW-1:0] rsp_top_offset_i,
  input wire logic [OffW-1:0] rsp_peak_usage_i
);

  // A waiting result stays offered until it is taken.
  `SAH_ASSERT_NEXT(a_rsp_hold, clk_i, rst_ni, rsp_valid_i && !rsp_ready_i, rsp_valid_i, "rsp dropped while stalled")

  // Only one request is worked on at a time.
  `SAH_ASSERT_NEXT(a_one_in_flight, clk_i, rst_ni, req_valid_i && req_ready_i, !req_ready_i, "second request taken during execute")

  `SAH_ASSERT(a_peak_covers_top, clk_i, rst_ni, rsp_valid_i |-> (rsp_peak_usage_i >= rsp_top_offset_i), "peak below top")

  // A granted block always ends at the new top, above its user offset.
  `SAH_ASSERT(a_grant_ok, clk_i, rst_ni, (rsp_valid_i && (rsp_grant_i != '0)) |-> ((rsp_status_i == 3'(ST_OK)) && (rsp_top_offset_i > rsp_grant_i)), "bad grant")

endmodule

bind stack_allocator_with_headers_unit sah_checker u_sah_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .req_valid_i      (req_i.valid),
  .req_ready_i      (req_i.ready),
  .rsp_valid_i      (rsp_o.valid),
  .rsp_ready_i      (rsp_o.ready),
  .rsp_status_i     (rsp_o.status),
  .rsp_grant_i      (rsp_o.grant_offset),
  .rsp_top_offset_i (rsp_o.top_offset),
  .rsp_peak_usage_i (rsp_o.peak_usage)
);

`default_nettype wire
